@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// List store package
// Sizes, request and response words, codes and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

   localparam int CAPACITY   = 64;
   localparam int ENTRY_BITS = 32;

   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int POS_BITS   = 7;
   localparam int VALUE_BITS = 32;
   localparam int CMP_BITS   = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_GET     = 2'd1,
      KIND_TAKE    = 2'd2,
      KIND_REPLACE = 2'd3
   } pls_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_NULL  = 2'd3
   } pls_status_type;

   typedef struct packed {
      pls_kind_type          req_type;
      logic [POS_BITS-1:0]   position;
      logic                  use_end;
      logic [VALUE_BITS-1:0] entry_value;
   } pls_req_type;

   typedef struct packed {
      pls_status_type        status;
      logic [VALUE_BITS-1:0] read_value;
      logic [POS_BITS-1:0]   entry_count;
   } pls_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ_OLD,
      S_CAP_OLD,
      S_LOOP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESPOND
   } pls_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rd_old;
      logic cap_old;
      logic shift_rd;
      logic shift_wr;
      logic finish;
   } pls_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic         err;
      pls_kind_type kind;
      logic         more;
   } pls_stat_type;

   function automatic logic [ENTRY_BITS-1:0] to_entry(input logic [VALUE_BITS-1:0] v);
      logic [63:0] wide;
      wide = {32'd0, v};
      return wide[ENTRY_BITS-1:0];
   endfunction

   function automatic logic [VALUE_BITS-1:0] from_entry(input logic [ENTRY_BITS-1:0] e);
      logic [63:0] wide;
      wide = 64'(e);
      return wide[VALUE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ src/positional_list_store.sv @@
// A request that fails a check goes straight to the response; get and replace
// read the addressed entry; insert shifts n = count - index entries, and take-out
// reads the entry and then shifts m = count - 1 - index entries.
// One request at a time: busy falls in the strobe cycle, so the next request can be
// accepted then; the shift loop, run once per moved entry, sets the rate.
// Synchronous reset empties the list and holds busy high; memory is not cleared.
// ----------------------------------------------------------------------------
// Positional list store
// Ordered list with insert, get, take-out and replace at an index or at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire pls_pkg::pls_req_type req_word,
   output pls_pkg::pls_rsp_type      rsp_word,
   output logic                      rsp_strobe
);
   import pls_pkg::*;

   // The controller and the datapath talk only through these two words.
   pls_cmd_type  cmd;
   pls_stat_type stat;

   // The controller walks each request through its steps: a check cycle,
   // an optional read of the addressed entry, an optional shift loop that moves
   // one entry per pass, and a closing cycle that writes the new entry of an
   // insert or replace, updates the count and loads the response register.
   pls_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the entry memory, the count and the response word.
   // The result word is registered, so rsp_strobe is high for exactly one
   // cycle and the receiver must take the word in that cycle.
   pls_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_word   (rsp_word),
      .rsp_strobe (rsp_strobe)
   );

endmodule

`default_nettype wire

@@ src/pls_ctrl.sv @@
// ----------------------------------------------------------------------------
// List store controller
// Sequences the read, shift and update steps of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pls_pkg::pls_stat_type stat,
   output pls_pkg::pls_cmd_type       cmd
);
   import pls_pkg::*;

   pls_state_type state_ff;
   pls_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            // No word is taken while reset is asserted.
            busy = reset;
            if (start && !reset) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.err) begin
               state_in = S_RESPOND;
            end else if (stat.kind == KIND_INSERT) begin
               state_in = S_LOOP;
            end else begin
               state_in = S_READ_OLD;
            end
         end
         S_READ_OLD: begin
            cmd.rd_old = 1'b1;
            state_in   = S_CAP_OLD;
         end
         S_CAP_OLD: begin
            cmd.cap_old = 1'b1;
            state_in    = (stat.kind == KIND_TAKE) ? S_LOOP : S_RESPOND;
         end
         S_LOOP: begin
            state_in = stat.more ? S_SHIFT_RD : S_RESPOND;
         end
         S_SHIFT_RD: begin
            cmd.shift_rd = 1'b1;
            state_in     = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_LOOP;
         end
         S_RESPOND: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/pls_datapath.sv @@
// ----------------------------------------------------------------------------
// List store datapath
// Request checks, entry memory, shift pointer, count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pls_pkg::pls_req_type req_word,
   input  wire pls_pkg::pls_cmd_type cmd,
   output pls_pkg::pls_stat_type     stat,
   output pls_pkg::pls_rsp_type      rsp_word,
   output logic                      rsp_strobe
);
   import pls_pkg::*;

   `include "assert_macros.svh"

   logic [ENTRY_BITS-1:0] mem [CAPACITY];

   pls_kind_type          kind_ff;
   pls_status_type        status_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [IDX_BITS-1:0]   ptr_ff;
   logic [ENTRY_BITS-1:0] val_ff;
   logic [ENTRY_BITS-1:0] rdata_ff;
   logic [ENTRY_BITS-1:0] old_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   pls_rsp_type           rsp_word_ff;
   logic                  rsp_strobe_ff;

   logic [ENTRY_BITS-1:0] req_val;
   logic                  req_null;
   logic [CMP_BITS-1:0]   pos_w;
   logic [CMP_BITS-1:0]   cnt_w;
   logic [CMP_BITS-1:0]   eff;
   pls_status_type        req_status;
   logic [IDX_BITS-1:0]   ptr_init;

   logic                  ok;
   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_wa;
   logic [ENTRY_BITS-1:0] mem_wd;
   logic                  mem_re;
   logic [IDX_BITS-1:0]   mem_ra;
   logic [IDX_BITS-1:0]   ptr_up;
   logic [IDX_BITS-1:0]   ptr_dn;
   logic                  take_done;

   // Request check at accept: effective index and status.
   always_comb begin
      req_val  = to_entry(req_word.entry_value);
      req_null = (req_val == '0);
      pos_w    = CMP_BITS'(req_word.position);
      cnt_w    = CMP_BITS'(count_ff);
      if (req_word.req_type == KIND_INSERT) begin
         eff = req_word.use_end ? cnt_w : pos_w;
         priority if (req_null) begin
            req_status = ST_NULL;
         end else if (eff > cnt_w) begin
            req_status = ST_RANGE;
         end else if (count_ff == CNT_BITS'(CAPACITY)) begin
            req_status = ST_FULL;
         end else begin
            req_status = ST_OK;
         end
         ptr_init = count_ff[IDX_BITS-1:0];
      end else begin
         eff = req_word.use_end ? (cnt_w - CMP_BITS'(1)) : pos_w;
         priority if (req_word.req_type == KIND_REPLACE && req_null) begin
            req_status = ST_NULL;
         end else if (req_word.use_end && count_ff == '0) begin
            req_status = ST_RANGE;
         end else if (eff >= cnt_w) begin
            req_status = ST_RANGE;
         end else begin
            req_status = ST_OK;
         end
         ptr_init = eff[IDX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_word.req_type;
         status_ff <= req_status;
         idx_ff    <= eff[IDX_BITS-1:0];
         val_ff    <= req_val;
      end
   end

   assign ok     = (status_ff == ST_OK);
   assign ptr_up = IDX_BITS'(ptr_ff + IDX_BITS'(1));
   assign ptr_dn = IDX_BITS'(ptr_ff - IDX_BITS'(1));

   // Shift pointer: inserts walk down from the count, take-outs walk up.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ptr_ff <= ptr_init;
      end else if (cmd.shift_wr) begin
         ptr_ff <= (kind_ff == KIND_INSERT) ? ptr_dn : ptr_up;
      end
   end

   always_comb begin
      stat.err  = !ok;
      stat.kind = kind_ff;
      if (kind_ff == KIND_INSERT) begin
         stat.more = (ptr_ff > idx_ff);
      end else if (kind_ff == KIND_TAKE) begin
         stat.more = ((CNT_BITS'(ptr_ff) + CNT_BITS'(1)) < count_ff);
      end else begin
         stat.more = 1'b0;
      end
   end

   // Entry memory: one write and one registered read per cycle.
   assign mem_re = cmd.rd_old | cmd.shift_rd;
   assign mem_ra = cmd.rd_old ? idx_ff :
                   ((kind_ff == KIND_INSERT) ? ptr_dn : ptr_up);
   assign mem_we = cmd.shift_wr |
                   (cmd.finish & ok &
                    ((kind_ff == KIND_INSERT) | (kind_ff == KIND_REPLACE)));
   assign mem_wa = cmd.shift_wr ? ptr_ff : idx_ff;
   assign mem_wd = cmd.shift_wr ? rdata_ff : val_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_old) begin
         old_ff <= rdata_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.finish && ok) begin
         if (kind_ff == KIND_INSERT) begin
            count_in = count_ff + CNT_BITS'(1);
         end else if (kind_ff == KIND_TAKE) begin
            count_in = count_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_ff.status      <= status_ff;
         rsp_word_ff.read_value  <= (ok && kind_ff != KIND_INSERT) ?
                                    from_entry(old_ff) : '0;
         rsp_word_ff.entry_count <= POS_BITS'(CMP_BITS'(count_in));
      end
   end

   assign rsp_word   = rsp_word_ff;
   assign rsp_strobe = rsp_strobe_ff;

   assign take_done = cmd.finish & ok & (kind_ff == KIND_TAKE);

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_BITS'(CAPACITY))
   `ASSERT_IMPLY(a_shift_only_ok, clock, reset, cmd.shift_wr || cmd.cap_old, ok)
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `ASSERT_NEXT(a_take_count, clock, reset, take_done, count_ff == $past(count_ff) - CNT_BITS'(1))

endmodule

`default_nettype wire

@@ sim/tb_positional_list_store.sv @@
// ----------------------------------------------------------------------------
// Positional list store testbench
// Drives insert, get, take-out and replace request words into the list store,
// keeps a mirror of the list to predict every response word, and compares
// each strobed response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_list_store;

   import pls_pkg::*;

   // Direction the random mix pushes the fill level in one phase.
   typedef enum int {
      TREND_GROW,
      TREND_MIXED,
      TREND_SHRINK
   } load_trend_type;

   localparam int PHASE_ITEMS  = 75;
   localparam int PHASE_COUNT  = 7;
   // Longest request is a shift across the whole list.
   localparam int SETTLE_TICKS = 4 + 3 * CAPACITY;
   localparam int REQ_BITS     = $bits(pls_req_type);

   // The mirror holds its own copy of the list. Every accepted request word
   // updates it and queues the response word the block must return; every
   // strobed response is checked against the head of that queue.
   class list_mirror;
      logic [ENTRY_BITS-1:0] slots[CAPACITY];
      int                    fill;
      int                    peak_fill;
      int                    full_rejects;
      int                    checked;
      int                    errors;
      int                    status_seen[4];
      pls_rsp_type           replies_due[$];

      function new();
         fill         = 0;
         peak_fill    = 0;
         full_rejects = 0;
         checked      = 0;
         errors       = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void note_request(pls_req_type r);
         pls_rsp_type           want;
         logic [ENTRY_BITS-1:0] val;
         int                    pos;
         int                    k;
         want.status     = ST_OK;
         want.read_value = '0;
         pos             = int'(r.position);
         val             = ENTRY_BITS'(r.entry_value);
         if (r.req_type == KIND_INSERT) begin
            // A null entry is rejected before the index is looked at.
            if (val == '0) begin
               want.status = ST_NULL;
            end else begin
               if (r.use_end) pos = fill;
               if (pos > fill) begin
                  want.status = ST_RANGE;
               end else if (fill >= CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  for (k = fill; k > pos; k--) slots[k] = slots[k-1];
                  slots[pos] = val;
                  fill++;
               end
            end
         end else if (r.req_type == KIND_REPLACE && val == '0) begin
            want.status = ST_NULL;
         end else if (r.use_end && fill == 0) begin
            want.status = ST_RANGE;
         end else begin
            if (r.use_end) pos = fill - 1;
            if (pos >= fill) begin
               want.status = ST_RANGE;
            end else begin
               want.read_value = VALUE_BITS'(slots[pos]);
               if (r.req_type == KIND_TAKE) begin
                  for (k = pos; k + 1 < fill; k++) slots[k] = slots[k+1];
                  fill--;
               end else if (r.req_type == KIND_REPLACE) begin
                  slots[pos] = val;
               end
            end
         end
         want.entry_count = POS_BITS'(fill);
         if (want.status == ST_FULL) full_rejects++;
         if (fill > peak_fill) peak_fill = fill;
         status_seen[want.status]++;
         replies_due.push_back(want);
      endfunction

      function void check_response(pls_rsp_type got);
         pls_rsp_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: response word with nothing outstanding: status %0d value %h count %0d",
                     $time, got.status, got.read_value, got.entry_count);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.read_value, got.read_value);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.entry_count, got.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   pls_req_type req_word;
   pls_rsp_type rsp_word;
   logic        rsp_strobe;

   list_mirror  mirror = new();
   int          words_sent;

   positional_list_store i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_word   (rsp_word),
      .rsp_strobe (rsp_strobe)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Both channels are observed at the rising edge. A response strobed in the
   // same cycle that a new request word is taken belongs to the older request,
   // so the check runs before the new prediction is queued.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) mirror.check_response(rsp_word);
         if (start && !busy) mirror.note_request(req_word);
      end
   end

   function automatic pls_req_type req_of(pls_kind_type kind, int pos, logic at_end,
                                          logic [VALUE_BITS-1:0] val);
      pls_req_type r;
      r.req_type    = kind;
      r.position    = POS_BITS'(pos);
      r.use_end     = at_end;
      r.entry_value = val;
      return r;
   endfunction

   // Present one request word from the falling edge on and hold it until the
   // block takes it. The busy value read right after the rising edge is the one
   // the block saw at that edge.
   task automatic send_word(pls_req_type r);
      @(negedge clock);
      start    = 1'b1;
      req_word = r;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // Hold start low for a number of cycles. The payload is scrambled meanwhile,
   // since the block must ignore it without start.
   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start    = 1'b0;
         req_word = REQ_BITS'({$urandom(), $urandom()});
      end
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic drain_replies();
      @(negedge clock);
      start = 1'b0;
      while (mirror.pending() != 0) @(negedge clock);
   endtask

   // Build one random request. Most positions land inside the legal range for
   // the current fill, some sit on or just past the boundary and a few are anywhere
   // in the seven-bit field.
   function automatic pls_req_type random_word(load_trend_type trend);
      pls_kind_type          kind;
      logic [VALUE_BITS-1:0] val;
      int                    grow_pct;
      int                    take_pct;
      int                    roll;
      int                    pos;
      int                    fill;
      case (trend)
         TREND_GROW: begin
            grow_pct = 85;
            take_pct = 5;
         end
         TREND_SHRINK: begin
            grow_pct = 10;
            take_pct = 70;
         end
         default: begin
            grow_pct = 35;
            take_pct = 30;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < grow_pct) kind = KIND_INSERT;
      else if (roll < grow_pct + take_pct) kind = KIND_TAKE;
      else if ($urandom_range(1) == 0) kind = KIND_GET;
      else kind = KIND_REPLACE;

      fill = mirror.fill;
      case ($urandom_range(9))
         0: pos = $urandom_range(127);
         1: pos = fill;
         2: pos = fill + 1;
         default: begin
            if (kind == KIND_INSERT) pos = $urandom_range(fill);
            else pos = (fill == 0) ? 0 : $urandom_range(fill - 1);
         end
      endcase

      case ($urandom_range(19))
         0: val = '0;
         1: val = '1;
         default: val = $urandom();
      endcase
      return req_of(kind, pos, $urandom_range(3) == 0, val);
   endfunction

   initial begin
      load_trend_type trend;
      bit             quiet;
      int             phase;
      int             n;

      reset      = 1'b1;
      start      = 1'b0;
      req_word   = '0;
      words_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. On the empty store: a get at an index, a take-out and a
      // replace at the end, a null replace (reported as null ahead of the range
      // check), a null insert and inserts past the count.
      send_word(req_of(KIND_GET,     0,   1'b0, 32'h0000_0009));
      send_word(req_of(KIND_TAKE,    0,   1'b1, 32'h0000_0000));
      send_word(req_of(KIND_REPLACE, 0,   1'b1, 32'h0000_0005));
      send_word(req_of(KIND_REPLACE, 0,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_INSERT,  0,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_INSERT,  127, 1'b0, 32'h0000_0007));
      send_word(req_of(KIND_INSERT,  1,   1'b0, 32'h0000_0007));
      // Build a short list: insert at the front, append by the end flag with
      // a position that must be ignored, insert in the middle, append by index.
      send_word(req_of(KIND_INSERT,  0,   1'b0, 32'hFFFF_FFFF));
      send_word(req_of(KIND_INSERT,  127, 1'b1, 32'h0000_0001));
      send_word(req_of(KIND_INSERT,  1,   1'b0, 32'h8000_0000));
      send_word(req_of(KIND_INSERT,  3,   1'b0, 32'h1234_5678));
      // Reads inside and outside the list.
      send_word(req_of(KIND_GET,     0,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_GET,     64,  1'b1, 32'h0000_0000));
      send_word(req_of(KIND_GET,     4,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_GET,     127, 1'b0, 32'h0000_0000));
      // Replace at an index, at the end, and one past the last entry.
      send_word(req_of(KIND_REPLACE, 1,   1'b0, 32'hA5A5_A5A5));
      send_word(req_of(KIND_REPLACE, 0,   1'b1, 32'h5A5A_5A5A));
      send_word(req_of(KIND_REPLACE, 4,   1'b0, 32'h0000_0003));
      // Take-out with a zero value, which is no error for a take-out, then
      // from the end, out of range, and down to an empty list.
      send_word(req_of(KIND_TAKE,    0,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_TAKE,    0,   1'b1, 32'h0000_0000));
      send_word(req_of(KIND_TAKE,    2,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_TAKE,    1,   1'b0, 32'h0000_0000));
      send_word(req_of(KIND_TAKE,    0,   1'b0, 32'hFFFF_FFFF));
      drain_replies();

      // Random part. Phases push the fill level up, hold it, and pull it down,
      // so the list is driven toward full and toward empty more than once. Some phases
      // run without gaps, and the last one never pauses.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 3)
            0: trend = TREND_GROW;
            1: trend = TREND_MIXED;
            default: trend = TREND_SHRINK;
         endcase
         quiet = (phase == PHASE_COUNT - 1) || ($urandom_range(2) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (!quiet && $urandom_range(3) == 0) hold_off($urandom_range(1, 11));
            send_word(random_word(trend));
         end
         if (phase != PHASE_COUNT - 1) drain_replies();
      end

      // Let the last response arrive, then watch for any stray strobe.
      drain_replies();
      repeat (SETTLE_TICKS) @(negedge clock);

      $display("Sent %0d request words, checked %0d responses; peak fill %0d of %0d.",
               words_sent, mirror.checked, mirror.peak_fill, CAPACITY);
      $display("Status mix: ok %0d, range %0d, full %0d, null %0d.",
               mirror.status_seen[ST_OK], mirror.status_seen[ST_RANGE],
               mirror.status_seen[ST_FULL], mirror.status_seen[ST_NULL]);
      if (mirror.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest legal run, where every request
   // shifts the whole list and every gap is at its longest.
   initial begin
      #20_000_000;
      $display("Timed out with %0d responses outstanding.", mirror.pending());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
